>>> src/ivef_pkg.sv
// ----------------------------------------------------------------------------
// ivef_pkg
// Shared types, control-word layout and microcode store for the
// inverse-variance expert fusion unit.
// ----------------------------------------------------------------------------
package ivef_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned ACC_W  = 64;
	localparam int unsigned PC_W   = 4;

	typedef logic [PC_W-1:0] pc_t;

	// datapath operation selected by one control word
	typedef enum logic [3:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_DIV,
		OP_PREC,
		OP_MUL_TERM,
		OP_ACC,
		OP_DIV_LOAD,
		OP_FVAR,
		OP_MUL_LO,
		OP_MUL_HI,
		OP_COMBINE,
		OP_EMIT
	} op_t;

	// jump condition, jump taken when true, else fall through
	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_ACCEPT,
		C_DIV_BUSY,
		C_NOT_LAST,
		C_OUT_BLOCKED
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   target;
	} ctrl_word_t;

	// program labels
	localparam pc_t PC_WAIT = PC_W'(0);
	localparam pc_t PC_DIV1 = PC_W'(1);
	localparam pc_t PC_DIV2 = PC_W'(6);
	localparam pc_t PC_EMIT = PC_W'(11);

	// microcode store
	function automatic ctrl_word_t ucode(input pc_t pc);
		ctrl_word_t cw;
		case (pc)
			PC_W'(0):  cw = '{OP_ACCEPT,   C_NO_ACCEPT,   PC_WAIT};
			PC_W'(1):  cw = '{OP_DIV,      C_DIV_BUSY,    PC_DIV1};
			PC_W'(2):  cw = '{OP_PREC,     C_NEVER,       PC_WAIT};
			PC_W'(3):  cw = '{OP_MUL_TERM, C_NEVER,       PC_WAIT};
			PC_W'(4):  cw = '{OP_ACC,      C_NOT_LAST,    PC_WAIT};
			PC_W'(5):  cw = '{OP_DIV_LOAD, C_NEVER,       PC_WAIT};
			PC_W'(6):  cw = '{OP_DIV,      C_DIV_BUSY,    PC_DIV2};
			PC_W'(7):  cw = '{OP_FVAR,     C_NEVER,       PC_WAIT};
			PC_W'(8):  cw = '{OP_MUL_LO,   C_NEVER,       PC_WAIT};
			PC_W'(9):  cw = '{OP_MUL_HI,   C_NEVER,       PC_WAIT};
			PC_W'(10): cw = '{OP_COMBINE,  C_NEVER,       PC_WAIT};
			PC_W'(11): cw = '{OP_EMIT,     C_OUT_BLOCKED, PC_EMIT};
			default:   cw = '{OP_NONE,     C_ALWAYS,      PC_WAIT};
		endcase
		return cw;
	endfunction

endpackage

>>> src/ivef_in_if.sv
// ----------------------------------------------------------------------------
// ivef_in_if
// Input channel: one expert prediction per item.
// ----------------------------------------------------------------------------
interface ivef_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] expert_mean;
	logic        [31:0] expert_var;
	logic               last_expert;
	logic               last_point;

	modport source (output valid, expert_mean, expert_var, last_expert, last_point,
		input ready);
	modport sink (input valid, expert_mean, expert_var, last_expert, last_point,
		output ready);
endinterface

>>> src/ivef_out_if.sv
// ----------------------------------------------------------------------------
// ivef_out_if
// Output channel: one fused prediction per item.
// ----------------------------------------------------------------------------
interface ivef_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] fused_mean;
	logic        [31:0] fused_var;
	logic               saturated;
	logic               batch_end;

	modport source (output valid, fused_mean, fused_var, saturated, batch_end,
		input ready);
	modport sink (input valid, fused_mean, fused_var, saturated, batch_end,
		output ready);
endinterface

>>> src/inverse_variance_expert_fusion_unit.sv
// ----------------------------------------------------------------------------
// inverse_variance_expert_fusion_unit
// Product-of-experts fusion of Gaussian predictions, driven by a microcoded
// sequencer over a shared radix-2 divider and a 32x32 multiplier.
// ----------------------------------------------------------------------------
// one expert at a time: a new expert is accepted only after the sequence
//   for the previous one has run to its end
// the fused item is registered after the final expert's divide, the second
//   divide, the multiplies and the combine, later while the previous fused
//   item is stalled; the shared divider makes one quotient bit per cycle
// reset: arst_n clears the program counter, step counter, running sums, flag
//   and output valid
module inverse_variance_expert_fusion_unit
	import ivef_pkg::*;
#(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	ivef_in_if.sink    expert,
	ivef_out_if.source fused
);

	// divider runs 2F+1 steps over the dividend 2^(2F)
	localparam int unsigned DIV_TOP = 2 * FRAC_BITS;
	localparam int unsigned CNT_W   = $clog2(DIV_TOP + 1);

	// sequencer
	pc_t        pc_q;
	pc_t        pc_nxt;
	ctrl_word_t cw;
	logic       jump;

	// handshakes
	logic in_fire;
	logic out_blocked;
	logic emit_fire;
	logic out_valid_q;

	// item registers
	logic [DATA_W-1:0] mmag_q;
	logic              neg_q;
	logic              last_e_q;
	logic              last_p_q;

	// divider
	logic [ACC_W-1:0]  div_d_q;
	logic [ACC_W-1:0]  div_rem_q;
	logic [DATA_W-1:0] div_quo_q;
	logic              div_qovf_q;
	logic              div_dz_q;
	logic [CNT_W-1:0]  div_cnt_q;
	logic [ACC_W:0]    rem_sh;
	logic [ACC_W+1:0]  rem_diff;
	logic              rem_ge;
	logic              div_sat;

	// multiplier and fused-mean path
	logic [DATA_W-1:0] recip_q;
	logic [DATA_W-1:0] mul_a;
	logic [ACC_W-1:0]  mul_p;
	logic [ACC_W-1:0]  prod_q;
	logic [ACC_W-1:0]  plo_q;
	logic [ACC_W-1:0]  wmag_q;
	logic              wneg_q;
	logic [ACC_W-1:0]  q_q;

	// running state of the current test point
	logic [ACC_W-1:0] psum_q;
	logic [ACC_W-1:0] wsum_q;
	logic             ovf_q;

	// combinational helpers
	logic [ACC_W:0]    psum_add;
	logic [ACC_W-1:0]  tmag;
	logic [ACC_W-1:0]  term;
	logic [ACC_W-1:0]  wsum_add;
	logic              wsum_ovf;
	logic [ACC_W-1:0]  wsum_sat;
	logic              phi_big;
	logic [ACC_W-1:0]  q_comb;
	logic              fmean_sat;
	logic [DATA_W-1:0] fmean;

	// output register payload
	logic [DATA_W-1:0] out_mean_q;
	logic [DATA_W-1:0] out_var_q;
	logic              out_sat_q;
	logic              out_end_q;

	// ---------------- sequencer ----------------
	assign cw           = ucode(pc_q);
	assign expert.ready = (cw.op == OP_ACCEPT);
	assign in_fire      = expert.valid && expert.ready;
	assign out_blocked  = out_valid_q && !fused.ready;
	assign emit_fire    = (cw.op == OP_EMIT) && !out_blocked;

	always_comb begin
		case (cw.cond)
			C_NEVER:       jump = 1'b0;
			C_ALWAYS:      jump = 1'b1;
			C_NO_ACCEPT:   jump = !expert.valid;
			C_DIV_BUSY:    jump = (div_cnt_q != '0);
			C_NOT_LAST:    jump = !last_e_q;
			C_OUT_BLOCKED: jump = out_blocked;
			default:       jump = 1'b0;
		endcase
		pc_nxt = jump ? cw.target : pc_q + PC_W'(1);
	end

	// ---------------- divider: floor(2^(2F) / d) ----------------
	// dividend has a single one at bit 2F, shifted in on the first step
	assign rem_sh   = {div_rem_q, (div_cnt_q == CNT_W'(DIV_TOP))};
	assign rem_diff = {1'b0, rem_sh} - {2'b00, div_d_q};
	assign rem_ge   = !rem_diff[ACC_W+1];
	assign div_sat  = div_dz_q || div_qovf_q;

	// ---------------- accumulate ----------------
	assign psum_add = {1'b0, psum_q} + {{(ACC_W-DATA_W+1){1'b0}}, recip_q};

	// term magnitude is below 2^(63-F), so the negation never wraps
	assign tmag     = prod_q >> FRAC_BITS;
	assign term     = neg_q ? (~tmag + ACC_W'(1)) : tmag;
	assign wsum_add = wsum_q + term;
	assign wsum_ovf = (wsum_q[ACC_W-1] == term[ACC_W-1]) &&
		(wsum_add[ACC_W-1] != wsum_q[ACC_W-1]);
	assign wsum_sat = term[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}}
		: {1'b0, {(ACC_W-1){1'b1}}};

	// ---------------- shared multiplier ----------------
	always_comb begin
		case (cw.op)
			OP_MUL_TERM: mul_a = mmag_q;
			OP_MUL_HI:   mul_a = wmag_q[ACC_W-1:DATA_W];
			default:     mul_a = wmag_q[DATA_W-1:0];
		endcase
	end

	// full 64-bit product of the two 32-bit operands
	assign mul_p = mul_a * recip_q;

	// high partial product at or above 2^(F-1) already overflows the mean
	assign phi_big = |prod_q[ACC_W-1:FRAC_BITS-1];
	assign q_comb  = phi_big ? (ACC_W'(1) << DATA_W)
		: (prod_q << (DATA_W - FRAC_BITS)) + (plo_q >> FRAC_BITS);

	// signed saturation of the fused mean
	always_comb begin
		if (wneg_q) begin
			fmean_sat = (q_q > (ACC_W'(1) << (DATA_W - 1)));
			fmean     = fmean_sat ? {1'b1, {(DATA_W-1){1'b0}}}
				: (~q_q[DATA_W-1:0] + DATA_W'(1));
		end else begin
			fmean_sat = (q_q > {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}});
			fmean     = fmean_sat ? {1'b0, {(DATA_W-1){1'b1}}} : q_q[DATA_W-1:0];
		end
	end

	// ---------------- control and running state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= PC_WAIT;
			out_valid_q <= 1'b0;
			div_cnt_q   <= '0;
			psum_q      <= '0;
			wsum_q      <= '0;
			ovf_q       <= 1'b0;
		end else begin
			pc_q <= pc_nxt;

			// output register: filled on emit, drained on handshake
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (fused.ready) begin
				out_valid_q <= 1'b0;
			end

			case (cw.op)
				OP_ACCEPT: begin
					if (in_fire) begin
						div_cnt_q <= CNT_W'(DIV_TOP);
					end
				end
				OP_DIV_LOAD: begin
					div_cnt_q <= CNT_W'(DIV_TOP);
				end
				OP_DIV: begin
					if (div_cnt_q != '0) begin
						div_cnt_q <= div_cnt_q - CNT_W'(1);
					end
				end
				OP_PREC: begin
					if (div_sat) begin
						ovf_q <= 1'b1;
					end
				end
				OP_MUL_TERM: begin
					// saturating add of the precision
					if (psum_add[ACC_W]) begin
						psum_q <= '1;
						ovf_q  <= 1'b1;
					end else begin
						psum_q <= psum_add[ACC_W-1:0];
					end
				end
				OP_ACC: begin
					if (wsum_ovf) begin
						wsum_q <= wsum_sat;
						ovf_q  <= 1'b1;
					end else begin
						wsum_q <= wsum_add;
					end
				end
				OP_FVAR: begin
					if (div_sat) begin
						ovf_q <= 1'b1;
					end
				end
				OP_EMIT: begin
					// result leaves, next test point starts clean
					if (emit_fire) begin
						psum_q <= '0;
						wsum_q <= '0;
						ovf_q  <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// ---------------- datapath payload ----------------
	always_ff @(posedge clk) begin
		case (cw.op)
			OP_ACCEPT: begin
				if (in_fire) begin
					neg_q      <= expert.expert_mean[DATA_W-1];
					mmag_q     <= expert.expert_mean[DATA_W-1]
						? (~expert.expert_mean + DATA_W'(1)) : expert.expert_mean;
					last_e_q   <= expert.last_expert;
					last_p_q   <= expert.last_point;
					div_d_q    <= {{(ACC_W-DATA_W){1'b0}}, expert.expert_var};
					div_dz_q   <= (expert.expert_var == '0);
					div_rem_q  <= '0;
					div_quo_q  <= '0;
					div_qovf_q <= 1'b0;
				end
			end
			OP_DIV_LOAD: begin
				div_d_q    <= psum_q;
				div_dz_q   <= (psum_q == '0);
				div_rem_q  <= '0;
				div_quo_q  <= '0;
				div_qovf_q <= 1'b0;
			end
			OP_DIV: begin
				// a quotient bit past bit 31 means the reciprocal saturates
				div_rem_q  <= rem_ge ? rem_diff[ACC_W-1:0] : rem_sh[ACC_W-1:0];
				div_quo_q  <= {div_quo_q[DATA_W-2:0], rem_ge};
				div_qovf_q <= div_qovf_q || div_quo_q[DATA_W-1];
			end
			OP_PREC: begin
				recip_q <= div_sat ? '1 : div_quo_q;
			end
			OP_MUL_TERM: begin
				prod_q <= mul_p;
			end
			OP_FVAR: begin
				recip_q <= div_sat ? '1 : div_quo_q;
				wneg_q  <= wsum_q[ACC_W-1];
				wmag_q  <= wsum_q[ACC_W-1] ? (~wsum_q + ACC_W'(1)) : wsum_q;
			end
			OP_MUL_LO: begin
				prod_q <= mul_p;
			end
			OP_MUL_HI: begin
				plo_q  <= prod_q;
				prod_q <= mul_p;
			end
			OP_COMBINE: begin
				q_q <= q_comb;
			end
			OP_EMIT: begin
				if (emit_fire) begin
					out_mean_q <= fmean;
					out_var_q  <= recip_q;
					out_sat_q  <= ovf_q || fmean_sat;
					out_end_q  <= last_p_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign fused.valid      = out_valid_q;
	assign fused.fused_mean = out_mean_q;
	assign fused.fused_var  = out_var_q;
	assign fused.saturated  = out_sat_q;
	assign fused.batch_end  = out_end_q;

endmodule

>>> src/ivef_checker.sv
// ----------------------------------------------------------------------------
// ivef_checker
// Port-level checks of the fusion unit, bound to the top level.
// ----------------------------------------------------------------------------
module ivef_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_mean,
	input logic [31:0] out_var,
	input logic        out_sat,
	input logic        out_end
);

	// stalled item stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output item dropped while stalled");

	// stalled item keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_mean) && $stable(out_var) &&
		$stable(out_sat) && $stable(out_end))
		else $error("output item changed while stalled");

	// one item in flight: the divider is busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item accepted while divider busy");

	// a result never follows an accept in the very next cycle
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_valid && in_ready))
		else $error("result appeared without the fusion run");

endmodule

bind inverse_variance_expert_fusion_unit ivef_checker u_ivef_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (expert.valid),
	.in_ready  (expert.ready),
	.out_valid (fused.valid),
	.out_ready (fused.ready),
	.out_mean  (fused.fused_mean),
	.out_var   (fused.fused_var),
	.out_sat   (fused.saturated),
	.out_end   (fused.batch_end)
);
